// ===== rtl/csv_enc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV record encoder package
// Shared types, character constants and helpers for the CSV record encoder.
// ----------------------------------------------------------------------------
package csv_enc_pkg;

	// Longest run of characters that one command can produce.
	localparam int MaxRun = 6;
	localparam int RunCntW = $clog2(MaxRun + 1);
	localparam int RunPosW = $clog2(MaxRun);

	typedef logic [7:0] char_t;
	typedef logic [MaxRun-1:0][7:0] run_bytes_t;
	typedef logic [RunCntW-1:0] run_cnt_t;
	typedef logic [RunPosW-1:0] run_pos_t;

	typedef enum logic [2:0] {
		CMD_VALUE       = 3'd0,
		CMD_FIELD_START = 3'd1,
		CMD_NEXT_VALUE  = 3'd2,
		CMD_FIELD_END   = 3'd3,
		CMD_RECORD_END  = 3'd4
	} cmd_t;

	// Record framing state carried between commands.
	typedef struct packed {
		logic emitted;
		logic multi;
	} rec_state_t;

	// Status of the output run buffer as seen by the input side.
	typedef struct packed {
		logic valid;
		logic free;
	} run_status_t;

	localparam char_t CH_COMMA     = 8'h2C;
	localparam char_t CH_QUOTE     = 8'h22;
	localparam char_t CH_LBRACKET  = 8'h5B;
	localparam char_t CH_RBRACKET  = 8'h5D;
	localparam char_t CH_BACKSLASH = 8'h5C;
	localparam char_t CH_SPACE     = 8'h20;
	localparam char_t CH_BANG      = 8'h21;
	localparam char_t CH_HASH      = 8'h23;
	localparam char_t CH_BS        = 8'h08;
	localparam char_t CH_TAB       = 8'h09;
	localparam char_t CH_LF        = 8'h0A;
	localparam char_t CH_FF        = 8'h0C;
	localparam char_t CH_CR        = 8'h0D;
	localparam char_t CH_LOW_B     = 8'h62;
	localparam char_t CH_LOW_F     = 8'h66;
	localparam char_t CH_LOW_N     = 8'h6E;
	localparam char_t CH_LOW_R     = 8'h72;
	localparam char_t CH_LOW_T     = 8'h74;
	localparam char_t CH_LOW_U     = 8'h75;
	localparam char_t CH_ZERO      = 8'h30;
	localparam char_t CH_UPPER_A   = 8'h41;

	// Upper-case hex digit for one nibble.
	function automatic char_t hex_digit(input logic [3:0] nib);
		char_t d;
		if (nib < 4'd10) begin
			d = CH_ZERO + {4'd0, nib};
		end else begin
			d = CH_UPPER_A + {4'd0, nib} - 8'd10;
		end
		return d;
	endfunction

endpackage

// ===== rtl/csv_enc_encode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV record encoder, command decode
// Turns one command into its run of output characters and the next state.
// ----------------------------------------------------------------------------
module csv_enc_encode import csv_enc_pkg::*; (
	input  logic [2:0] cmd,
	input  char_t      data_byte,
	input  logic       multi_value,
	input  rec_state_t state_cur,
	output rec_state_t state_nxt,
	output run_bytes_t run_bytes,
	output run_cnt_t   run_cnt
);

	logic  pass;
	char_t esc;

	// Printable bytes other than quote and backslash, and everything from 0x7F up.
	assign pass = ((data_byte >= CH_HASH) && (data_byte <= CH_LBRACKET)) ||
		(data_byte >= CH_RBRACKET) || (data_byte == CH_SPACE) || (data_byte == CH_BANG);

	always_comb begin
		case (data_byte)
			CH_QUOTE:     esc = CH_QUOTE;
			CH_BACKSLASH: esc = CH_BACKSLASH;
			CH_BS:        esc = CH_LOW_B;
			CH_FF:        esc = CH_LOW_F;
			CH_LF:        esc = CH_LOW_N;
			CH_CR:        esc = CH_LOW_R;
			CH_TAB:       esc = CH_LOW_T;
			default:      esc = '0;
		endcase
	end

	always_comb begin
		run_bytes = '0;
		run_cnt   = '0;
		state_nxt = state_cur;
		unique case (cmd)
			CMD_VALUE: begin
				if (pass) begin
					run_bytes[0] = data_byte;
					run_cnt      = RunCntW'(1);
				end else if (esc != '0) begin
					run_bytes[0] = CH_BACKSLASH;
					run_bytes[1] = esc;
					run_cnt      = RunCntW'(2);
				end else begin
					run_bytes[0] = CH_BACKSLASH;
					run_bytes[1] = CH_LOW_U;
					run_bytes[2] = CH_ZERO;
					run_bytes[3] = CH_ZERO;
					run_bytes[4] = hex_digit(data_byte[7:4]);
					run_bytes[5] = hex_digit(data_byte[3:0]);
					run_cnt      = RunCntW'(6);
				end
			end
			CMD_FIELD_START: begin
				if (state_cur.emitted) begin
					run_bytes[0] = CH_COMMA;
					run_bytes[1] = CH_QUOTE;
					run_bytes[2] = CH_LBRACKET;
					run_cnt      = multi_value ? RunCntW'(3) : RunCntW'(2);
				end else begin
					run_bytes[0] = CH_QUOTE;
					run_bytes[1] = CH_LBRACKET;
					run_cnt      = multi_value ? RunCntW'(2) : RunCntW'(1);
				end
				state_nxt.emitted = 1'b1;
				state_nxt.multi   = multi_value;
			end
			CMD_NEXT_VALUE: begin
				if (state_cur.multi) begin
					run_bytes[0] = CH_COMMA;
					run_cnt      = RunCntW'(1);
				end
			end
			CMD_FIELD_END: begin
				if (state_cur.multi) begin
					run_bytes[0] = CH_RBRACKET;
					run_bytes[1] = CH_QUOTE;
					run_cnt      = RunCntW'(2);
				end else begin
					run_bytes[0] = CH_QUOTE;
					run_cnt      = RunCntW'(1);
				end
				state_nxt.multi = 1'b0;
			end
			CMD_RECORD_END: begin
				state_nxt = '0;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/csv_enc_run.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV record encoder, run buffer
// Holds one run of characters; hands out one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module csv_enc_run import csv_enc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  run_bytes_t  load_bytes,
	input  run_cnt_t    load_cnt,
	output run_status_t status,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output char_t       m_axis_tdata,
	output logic        m_axis_tlast
);

	run_bytes_t bytes_q;
	run_cnt_t   cnt_q;
	run_pos_t   pos_q;
	logic       valid_q;
	logic       take;
	logic       last;

	assign last = (RunCntW'(pos_q) == (cnt_q - RunCntW'(1)));
	assign take = valid_q && m_axis_tready;

	assign status.valid = valid_q;
	assign status.free  = !valid_q || (take && last);

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = bytes_q[pos_q];
	assign m_axis_tlast  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			pos_q   <= '0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				pos_q <= pos_q + RunPosW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= load_bytes;
			cnt_q   <= load_cnt;
		end
	end

endmodule

// ===== rtl/csv_record_escape_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV record escape encoder
// Encodes a stream of record-framing commands into quoted, escaped CSV text.
// ----------------------------------------------------------------------------
// Usage:
// Each input word on the slave stream is one command: a value byte, field
// start, next value, field end or record end. The master stream carries the
// encoded characters, one per word, with tlast set on the final character
// that a command produced. Commands that produce nothing (record end, next
// value in a single-value field, unused codes) emit no word at all.
// Data path: a taken command waits in the input register, is decoded from
// there, and its run is loaded into the run buffer that feeds the master.
// Throughput: while the receiver is ready, the run buffer drains one
// character per cycle. A command produces from one to six characters
// (six for a control byte written as a \u00XX escape); commands that emit
// nothing leave the input register without loading the run buffer. A new
// command is taken in the same cycle that the last character of the
// previous run leaves, so while the receiver is ready single-character
// commands flow at one word per cycle.
// Reset clears the framing state (no field emitted, not multi-valued) and
// empties both the input register and the run buffer.
// When the receiver stalls, the current character holds, the input register
// fills and then s_axis_tready drops until the run drains.
// ----------------------------------------------------------------------------
module csv_record_escape_encoder_core import csv_enc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [3:0] s_axis_tuser,   // [2:0] command, [3] multi_value
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast    // last_of_run
);

	// Input register: one command waiting to be decoded.
	logic       valid_s1;
	logic [2:0] cmd_s1;
	char_t      data_s1;
	logic       multi_s1;

	// Framing state: whether a field has been started in this record, and
	// whether the open field is multi-valued.
	rec_state_t state_q;
	rec_state_t state_nxt;

	run_bytes_t  run_bytes;
	run_cnt_t    run_cnt;
	run_status_t run_status;

	logic accept;
	logic adv;
	logic load;

	// A decoded command leaves the input register when it has nothing to
	// emit, or when the run buffer is empty or releasing its last character.
	assign adv    = valid_s1 && ((run_cnt == '0) || run_status.free);
	assign load   = adv && (run_cnt != '0);
	assign accept = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= s_axis_tuser[2:0];
			data_s1  <= s_axis_tdata;
			multi_s1 <= s_axis_tuser[3];
		end
	end

	csv_enc_encode u_encode (
		.cmd         (cmd_s1),
		.data_byte   (data_s1),
		.multi_value (multi_s1),
		.state_cur   (state_q),
		.state_nxt   (state_nxt),
		.run_bytes   (run_bytes),
		.run_cnt     (run_cnt)
	);

	csv_enc_run u_run (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.load_bytes    (run_bytes),
		.load_cnt      (run_cnt),
		.status        (run_status),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// A run is only loaded into a buffer that is empty or just emptied.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!run_status.valid || (m_axis_tready && m_axis_tlast)))
		else $error("run buffer overwritten while characters remain");

	// The final character leaving without a new load empties the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast && !load) |=> !m_axis_tvalid)
		else $error("run buffer still valid after its last character");

	// A record end clears the framing state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (cmd_s1 == CMD_RECORD_END)) |=> (state_q == '0))
		else $error("framing state not cleared by record end");

	// An empty input register always takes a new command.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with an empty input register");

endmodule
